/* sv/pidt_pkg.sv */
// pidt_pkg: widths, constants, control types and FSM encoding for the tilt PID drive.
// Used by every module of pid_tilt_motor_drive and by its checker.
// No dependencies.
package pidt_pkg;

  localparam int SUM_W  = 32;            // running integral width
  localparam int SUMX_W = SUM_W + 1;     // integral plus one guard bit
  localparam int TILT_W = 17;
  localparam int DIFF_W = TILT_W + 1;    // last_error - tilt
  localparam int GAIN_W = 16;
  localparam int CNT_W  = $clog2(GAIN_W);
  localparam int HI_W   = SUM_W + 3;     // upper product accumulator
  localparam int ACC_W  = HI_W + GAIN_W; // full Kp*e + Kd*d + Ki*s
  localparam int DRIVE_W = 9;
  localparam int DUTY_W  = 8;

  // drive = trunc(acc * 255 / (90 * 2^16)); 255 / (90 * 2^16) = 17 / (3 * 2^17)
  localparam int MAG_W   = 23;           // DEN fits in 23 bits
  localparam logic [MAG_W-1:0] SCALE_DEN = MAG_W'(90 * 65536);
  localparam int T_SHIFT = 17;
  localparam int PROD_W  = MAG_W + 4;    // mag * 17
  localparam int T_W     = PROD_W - T_SHIFT;
  localparam logic [T_W-1:0] RECIP3 = T_W'(683); // ~2^11 / 3, exact floor for t < 765
  localparam int RECIP_SH = 11;
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(255);

  localparam logic signed [GAIN_W-1:0] KP_RESET = GAIN_W'(256);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_MAG  = 5'b00100,
    ST_SCL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;   // beat accepted: load gains, clear accumulator
    logic step;    // one gain bit per cycle
    logic last;    // sign bit of the gains: subtract
    logic mag_en;  // capture sign and magnitude
    logic scl_en;  // capture scaled magnitude
  } ctrl_t;

endpackage

/* sv/pidt_prep.sv */
// pidt_prep: per-sample state update (saturating integral, derivative, direction).
// Depends on pidt_pkg.
module pidt_prep (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  accept,
  input  logic signed [pidt_pkg::TILT_W-1:0]    tilt,
  output logic signed [pidt_pkg::TILT_W-1:0]    err,
  output logic signed [pidt_pkg::DIFF_W-1:0]    diff,
  output logic signed [pidt_pkg::SUM_W-1:0]     sum,
  output logic                                  dir
);

  logic signed [pidt_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [pidt_pkg::TILT_W-1:0] last_r;
  logic signed [pidt_pkg::DIFF_W-1:0] diff_r, diff_nxt;
  logic                               dir_r, dir_nxt;
  logic        [pidt_pkg::SUMX_W-1:0] sum_wide;

  assign sum_wide = {sum_r[pidt_pkg::SUM_W-1], sum_r}
                  + {{(pidt_pkg::SUMX_W-pidt_pkg::TILT_W){tilt[pidt_pkg::TILT_W-1]}}, tilt};

  always_comb begin
    // guard bit disagrees with sign: clip to the rail
    if (sum_wide[pidt_pkg::SUM_W] != sum_wide[pidt_pkg::SUM_W-1]) begin
      sum_nxt = sum_wide[pidt_pkg::SUM_W]
              ? {1'b1, {(pidt_pkg::SUM_W-1){1'b0}}}
              : {1'b0, {(pidt_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[pidt_pkg::SUM_W-1:0];
    end
    diff_nxt = {last_r[pidt_pkg::TILT_W-1], last_r} - {tilt[pidt_pkg::TILT_W-1], tilt};
    if (tilt != '0) begin
      dir_nxt = ~tilt[pidt_pkg::TILT_W-1];
    end else begin
      dir_nxt = dir_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      last_r <= '0;
      dir_r  <= 1'b0;
    end else if (accept) begin
      sum_r  <= sum_nxt;
      last_r <= tilt;
      dir_r  <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r <= diff_nxt;
    end
  end

  assign err  = last_r;
  assign diff = diff_r;
  assign sum  = sum_r;
  assign dir  = dir_r;

endmodule

/* sv/pidt_mac.sv */
// pidt_mac: serial-parallel multiply-accumulate, one gain bit of all three gains per cycle.
// Depends on pidt_pkg.
module pidt_mac (
  input  logic                                  clk,
  input  pidt_pkg::ctrl_t                       ctrl,
  input  logic signed [pidt_pkg::GAIN_W-1:0]    kp,
  input  logic signed [pidt_pkg::GAIN_W-1:0]    kd,
  input  logic signed [pidt_pkg::GAIN_W-1:0]    ki,
  input  logic signed [pidt_pkg::TILT_W-1:0]    err,
  input  logic signed [pidt_pkg::DIFF_W-1:0]    diff,
  input  logic signed [pidt_pkg::SUM_W-1:0]     sum,
  output logic        [pidt_pkg::ACC_W-1:0]     acc
);

  logic [pidt_pkg::GAIN_W-1:0] kp_sr_r, kd_sr_r, ki_sr_r;
  logic [pidt_pkg::HI_W-1:0]   hi_r, hi_nxt;
  logic [pidt_pkg::GAIN_W-1:0] lo_r, lo_nxt;
  logic [pidt_pkg::HI_W-1:0]   ext_e, ext_d, ext_s, partial, total;

  assign ext_e = {{(pidt_pkg::HI_W-pidt_pkg::TILT_W){err[pidt_pkg::TILT_W-1]}}, err};
  assign ext_d = {{(pidt_pkg::HI_W-pidt_pkg::DIFF_W){diff[pidt_pkg::DIFF_W-1]}}, diff};
  assign ext_s = {{(pidt_pkg::HI_W-pidt_pkg::SUM_W){sum[pidt_pkg::SUM_W-1]}}, sum};

  always_comb begin
    partial = (kp_sr_r[0] ? ext_e : '0)
            + (kd_sr_r[0] ? ext_d : '0)
            + (ki_sr_r[0] ? ext_s : '0);
    // gain MSB carries weight -2^15
    total  = ctrl.last ? (hi_r - partial) : (hi_r + partial);
    hi_nxt = {total[pidt_pkg::HI_W-1], total[pidt_pkg::HI_W-1:1]};
    lo_nxt = {total[0], lo_r[pidt_pkg::GAIN_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      kp_sr_r <= kp;
      kd_sr_r <= kd;
      ki_sr_r <= ki;
      hi_r    <= '0;
      lo_r    <= '0;
    end else if (ctrl.step) begin
      kp_sr_r <= {1'b0, kp_sr_r[pidt_pkg::GAIN_W-1:1]};
      kd_sr_r <= {1'b0, kd_sr_r[pidt_pkg::GAIN_W-1:1]};
      ki_sr_r <= {1'b0, ki_sr_r[pidt_pkg::GAIN_W-1:1]};
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
    end
  end

  assign acc = {hi_r, lo_r};

endmodule

/* sv/pidt_scale.sv */
// pidt_scale: degree-to-drive rescale, truncation toward zero and clamp to +-255.
// Depends on pidt_pkg.
module pidt_scale (
  input  logic                                  clk,
  input  pidt_pkg::ctrl_t                       ctrl,
  input  logic        [pidt_pkg::ACC_W-1:0]     acc,
  output logic signed [pidt_pkg::DRIVE_W-1:0]   drive,
  output logic        [pidt_pkg::DUTY_W-1:0]    duty
);

  logic [pidt_pkg::ACC_W-1:0]        amag;
  logic                              neg_r, neg2_r, big_r, big2_r, big_nxt;
  logic [pidt_pkg::MAG_W-1:0]        mag_r;
  logic [pidt_pkg::PROD_W-1:0]       prod17;
  logic [pidt_pkg::T_W-1:0]          t_r;
  logic [2*pidt_pkg::T_W-1:0]        qprod;
  logic [pidt_pkg::DUTY_W-1:0]       duty_c;

  assign amag = acc[pidt_pkg::ACC_W-1]
              ? (~acc + {{(pidt_pkg::ACC_W-1){1'b0}}, 1'b1})
              : acc;
  // |acc| >= 90*2^16 scales to at least 255
  assign big_nxt = (amag[pidt_pkg::ACC_W-1:pidt_pkg::MAG_W] != '0)
                || (amag[pidt_pkg::MAG_W-1:0] >= pidt_pkg::SCALE_DEN);

  always_ff @(posedge clk) begin
    if (ctrl.mag_en) begin
      neg_r <= acc[pidt_pkg::ACC_W-1];
      big_r <= big_nxt;
      mag_r <= amag[pidt_pkg::MAG_W-1:0];
    end
  end

  // floor(mag*17 / 2^17), then floor(/3) below
  assign prod17 = {mag_r, 4'b0000} + {4'b0000, mag_r};

  always_ff @(posedge clk) begin
    if (ctrl.scl_en) begin
      neg2_r <= neg_r;
      big2_r <= big_r;
      t_r    <= prod17[pidt_pkg::PROD_W-1:pidt_pkg::T_SHIFT];
    end
  end

  assign qprod  = t_r * pidt_pkg::RECIP3;
  assign duty_c = big2_r ? pidt_pkg::DUTY_MAX
                : qprod[pidt_pkg::RECIP_SH+pidt_pkg::DUTY_W-1:pidt_pkg::RECIP_SH];

  assign duty  = duty_c;
  assign drive = neg2_r ? (~{1'b0, duty_c} + {{(pidt_pkg::DRIVE_W-1){1'b0}}, 1'b1})
                        : {1'b0, duty_c};

endmodule

/* sv/pid_tilt_motor_drive.sv */
// pid_tilt_motor_drive: top level, sequencer, gain registers and output register.
// Depends on pidt_pkg, pidt_prep, pidt_mac, pidt_scale.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, in_tilt_angle        | sample in
//  out     | out_valid, out_stall, out_drive_level,   | drive out
//          | out_duty, out_forward_dir                |
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata          | gain write
//
// A sample passes through the accept cycle, the bit-serial multiply-accumulate
// (one bit of each gain per cycle) and then three rescale steps.
// The next sample can be taken once the result has entered the output register.
// A stalled result holds in the output register; a finished result waits in ST_FIN
// for a free output register. Reset (synchronous, active low) clears integral,
// last error, direction and gains to their reset values.
module pid_tilt_motor_drive (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pidt_pkg::TILT_W-1:0]    in_tilt_angle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pidt_pkg::DRIVE_W-1:0]   out_drive_level,
  output logic        [pidt_pkg::DUTY_W-1:0]    out_duty,
  output logic                                  out_forward_dir,
  input  logic                                  cfg_wr_en,
  input  logic        [pidt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pidt_pkg::GAIN_W-1:0]    cfg_wdata
);

  pidt_pkg::state_t                   state_r, state_nxt;
  logic [pidt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  pidt_pkg::ctrl_t                    ctrl;
  logic                               accept, finish;
  logic signed [pidt_pkg::GAIN_W-1:0] kp_r, kd_r, ki_r;

  logic signed [pidt_pkg::TILT_W-1:0]  err;
  logic signed [pidt_pkg::DIFF_W-1:0]  diff;
  logic signed [pidt_pkg::SUM_W-1:0]   sum;
  logic                                dir;
  logic        [pidt_pkg::ACC_W-1:0]   acc;
  logic signed [pidt_pkg::DRIVE_W-1:0] drive;
  logic        [pidt_pkg::DUTY_W-1:0]  duty;

  logic                                out_valid_r;
  logic signed [pidt_pkg::DRIVE_W-1:0] out_drive_r;
  logic        [pidt_pkg::DUTY_W-1:0]  out_duty_r;
  logic                                out_dir_r;

  assign in_stall = (state_r != pidt_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign finish   = (state_r == pidt_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ctrl        = '0;
    ctrl.start  = accept;
    case (state_r)
      pidt_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = pidt_pkg::ST_MAC;
        end
      end
      pidt_pkg::ST_MAC: begin
        ctrl.step = 1'b1;
        ctrl.last = (cnt_r == pidt_pkg::CNT_W'(pidt_pkg::GAIN_W - 1));
        cnt_nxt   = cnt_r + pidt_pkg::CNT_W'(1);
        if (ctrl.last) begin
          state_nxt = pidt_pkg::ST_MAG;
        end
      end
      pidt_pkg::ST_MAG: begin
        ctrl.mag_en = 1'b1;
        state_nxt   = pidt_pkg::ST_SCL;
      end
      pidt_pkg::ST_SCL: begin
        ctrl.scl_en = 1'b1;
        state_nxt   = pidt_pkg::ST_FIN;
      end
      pidt_pkg::ST_FIN: begin
        if (finish) begin
          state_nxt = pidt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pidt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // gains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= pidt_pkg::KP_RESET;
      kd_r <= '0;
      ki_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pidt_pkg::REG_KP: kp_r <= cfg_wdata;
        pidt_pkg::REG_KD: kd_r <= cfg_wdata;
        pidt_pkg::REG_KI: ki_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pidt_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .tilt   (in_tilt_angle),
    .err    (err),
    .diff   (diff),
    .sum    (sum),
    .dir    (dir)
  );

  pidt_mac u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .kp   (kp_r),
    .kd   (kd_r),
    .ki   (ki_r),
    .err  (err),
    .diff (diff),
    .sum  (sum),
    .acc  (acc)
  );

  pidt_scale u_scale (
    .clk   (clk),
    .ctrl  (ctrl),
    .acc   (acc),
    .drive (drive),
    .duty  (duty)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_drive_r <= drive;
      out_duty_r  <= duty;
      out_dir_r   <= dir;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_level = out_drive_r;
  assign out_duty        = out_duty_r;
  assign out_forward_dir = out_dir_r;

endmodule

/* sv/pidt_chk.sv */
// pidt_chk: port-level checks for pid_tilt_motor_drive, bound to the top level.
// Depends on pidt_pkg and pid_tilt_motor_drive.
module pidt_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [pidt_pkg::DRIVE_W-1:0]   out_drive_level,
  input logic        [pidt_pkg::DUTY_W-1:0]    out_duty,
  input logic                                  out_forward_dir
);

  // a sample keeps the block busy for the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken back to back");

  a_duty_is_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_level[pidt_pkg::DRIVE_W-1]
      ? (out_duty == (~out_drive_level[pidt_pkg::DUTY_W-1:0] + 8'd1))
      : (out_duty == out_drive_level[pidt_pkg::DUTY_W-1:0])))
    else $error("duty does not match drive magnitude");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_level != 9'sh100))
    else $error("drive beyond -255");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_drive_level)
      && $stable(out_forward_dir)))
    else $error("stalled result changed");

endmodule

bind pid_tilt_motor_drive pidt_chk u_pidt_chk (.*);
